// File: hdl/adjacency_matrix_graph_store_defines.svh
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_defines
// Assertion macros used by the graph store module.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_DEFINES_SVH
// a implies b on the next edge
`define AMG_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// a implies b on the same edge
`define AMG_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// File: hdl/amg_pkg.sv
// ----------------------------------------------------------------------------
// amg_pkg
// Command and status codes of the graph store.
// ----------------------------------------------------------------------------
package amg_pkg;
    typedef enum logic [3:0] {
        CMD_ADD_V   = 4'd0,
        CMD_REM_V   = 4'd1,
        CMD_ADD_E   = 4'd2,
        CMD_REM_E   = 4'd3,
        CMD_ADJ     = 4'd4,
        CMD_NBR     = 4'd5,
        CMD_GET_V   = 4'd6,
        CMD_SET_V   = 4'd7,
        CMD_GET_E   = 4'd8,
        CMD_SET_E   = 4'd9
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;
endpackage

// File: hdl/adjacency_matrix_graph_store.sv
// After the accepting edge each command is decoded in S_DONE, raising out_valid for
// most commands; get edge reads via S_RD_E and S_RD_E2; add vertex clears row n, then
// column n of edge values; remove vertex reads then writes each edge cell in turn;
// neighbor listing scans one row bit per cycle, pausing at each neighbor to load its item.
// One item at a time: ready only in idle, reached the cycle after the last result goes.
// Reset (rst_n, async low) clears vertex count and control; stores are not cleared.
`include "adjacency_matrix_graph_store_defines.svh"
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Directed graph store with adjacency bits, vertex values and edge values,
// run by a small sequencer over one edge-memory port and a row scanner.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store
    import amg_pkg::*;
#(
    parameter int MAX_VERTICES      = 16,
    parameter int VERTEX_VALUE_BITS = 16,
    parameter int EDGE_VALUE_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [3:0]  first_index,
    input  logic [3:0]  second_index,
    input  logic [15:0] value,
    input  logic        option_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        is_adjacent,
    output logic [15:0] read_value,
    output logic [3:0]  neighbor_index,
    output logic [4:0]  vertex_total,
    output logic        last
);
    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = 2 * IW;
    localparam int KW = (CW > 4) ? CW : 4;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_E, S_REM_RD, S_REM_WR, S_RD_E, S_RD_E2,
        S_NBR, S_NBR_OUT, S_WAIT, S_DONE
    } state_t;

    // range checks compare index and count at KW bits, wide enough for both
    logic [3:0] x_reg, y_reg;
    logic [15:0] val_reg;
    logic opt_reg;
    cmd_t cmd_reg;
    state_t state_reg;
    logic [CW-1:0] n_reg;
    logic [IW-1:0] ci_reg, cj_reg;           // sweep row / column
    logic [MAX_VERTICES-1:0] rows_reg [MAX_VERTICES];
    logic [VERTEX_VALUE_BITS-1:0] vval_reg [MAX_VERTICES];
    logic [EDGE_VALUE_BITS-1:0] emem [MAX_VERTICES*MAX_VERTICES];
    logic [EDGE_VALUE_BITS-1:0] erd_reg;
    logic [MAX_VERTICES-1:0] scan_reg;
    logic found_reg;
    logic ov_reg;
    logic [1:0] st_reg;
    logic adj_reg, last_reg;
    logic [15:0] rv_reg;
    logic [3:0] ni_reg;

    // edge memory port
    logic            e_we;
    logic [EW-1:0]   e_waddr, e_raddr;
    logic [EDGE_VALUE_BITS-1:0] e_wdata;

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[e_waddr] <= e_wdata;
        erd_reg <= emem[e_raddr];
    end

    logic in_fire, out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (state_reg == S_IDLE);

    logic [CW-1:0] xw, yw, ciw, cjw;
    assign xw  = CW'(x_reg);
    assign yw  = CW'(y_reg);
    assign ciw = CW'(ci_reg);
    assign cjw = CW'(cj_reg);
    logic xok, xyok;
    assign xok  = (KW'(x_reg) < KW'(n_reg));
    assign xyok = xok && (KW'(y_reg) < KW'(n_reg));
    logic [IW-1:0] xi, yi, ni;
    assign xi = IW'(x_reg);
    assign yi = IW'(y_reg);
    assign ni = n_reg[IW-1:0];

    // Edge sweep schedule. Add vertex: clear row n and column n.
    // Remove vertex: for each target cell (i,j) of the new (n-1)x(n-1) block,
    // copy from (i>=x ? i+1 : i, j>=x ? j+1 : j); row/col n-1 cleared.
    logic [CW-1:0] si, sj;
    assign si = (ciw >= xw) ? ciw + 1'b1 : ciw;
    assign sj = (cjw >= xw) ? cjw + 1'b1 : cjw;
    logic src_live;
    assign src_live = (si < n_reg) && (sj < n_reg);
    logic [EW-1:0] rem_src;
    assign rem_src = {si[IW-1:0], sj[IW-1:0]};
    logic sweep_end;
    assign sweep_end = (ci_reg == IW'(MAX_VERTICES - 1)) && (cj_reg == IW'(MAX_VERTICES - 1));

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = {ci_reg, cj_reg};
        e_wdata = '0;
        e_raddr = {xi, yi};
        case (state_reg)
            S_DONE:
            begin
                // set edge writes straight through the port
                if (cmd_reg == CMD_SET_E && xyok)
                begin
                    e_we    = 1'b1;
                    e_waddr = {xi, yi};
                    e_wdata = EDGE_VALUE_BITS'(val_reg);
                end
            end
            S_ADD_E:
            begin
                // first pass rows (ci==0 -> row n), second columns; pass chosen by ci[0], cj sweeps the cells
                e_we    = 1'b1;
                e_waddr = ci_reg[0] ? {cj_reg, ni} : {ni, cj_reg};
            end
            S_REM_RD: e_raddr = rem_src;
            S_REM_WR:
            begin
                e_we    = 1'b1;
                e_wdata = src_live ? erd_reg : '0;
            end
            default: ;
        endcase
    end

    // drop bit p from a row
    function automatic logic [MAX_VERTICES-1:0] drop_bit(
        input logic [MAX_VERTICES-1:0] r, input logic [IW-1:0] p);
        logic [MAX_VERTICES-1:0] m, res;
        m   = ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << p) - 1'b1;
        res = (r & m) | ((r >> 1) & ~m);
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (out_fire)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        cmd_reg <= cmd_t'(command);
                        x_reg <= first_index;
                        y_reg <= second_index;
                        val_reg <= value;
                        opt_reg <= option_flag;
                        ci_reg <= '0;
                        cj_reg <= '0;
                        state_reg <= S_DONE;
                    end
                S_DONE:
                begin
                    st_reg <= ST_OK; adj_reg <= 1'b0; rv_reg <= '0;
                    ni_reg <= '0; last_reg <= 1'b1;
                    state_reg <= S_WAIT;
                    case (cmd_reg)
                        CMD_ADD_V:
                            if (n_reg >= CW'(MAX_VERTICES)) st_reg <= ST_FULL;
                            else
                            begin
                                for (int i = 0; i < MAX_VERTICES; i++)
                                    rows_reg[i][ni] <= 1'b0;
                                rows_reg[ni] <= '0;
                                rows_reg[ni][ni] <= opt_reg;
                                vval_reg[ni] <= VERTEX_VALUE_BITS'(val_reg);
                                state_reg <= S_ADD_E;
                            end
                        CMD_REM_V:
                            if (!xok) st_reg <= ST_RANGE;
                            else
                            begin
                                // top row keeps stale data; it is outside the live range
                                for (int i = 0; i < MAX_VERTICES - 1; i++)
                                begin
                                    if (CW'(i) >= xw)
                                    begin
                                        rows_reg[i] <= drop_bit(rows_reg[i+1], xi);
                                        vval_reg[i] <= vval_reg[i+1];
                                    end
                                    else
                                        rows_reg[i] <= drop_bit(rows_reg[i], xi);
                                end
                                state_reg <= S_REM_RD;
                            end
                        CMD_ADD_E, CMD_REM_E:
                            if (!xyok) st_reg <= ST_RANGE;
                            else
                            begin
                                rows_reg[xi][yi] <= (cmd_reg == CMD_ADD_E);
                                if (opt_reg)
                                    rows_reg[yi][xi] <= (cmd_reg == CMD_ADD_E);
                            end
                        CMD_ADJ:
                            if (!xyok) st_reg <= ST_RANGE;
                            else adj_reg <= rows_reg[xi][yi];
                        CMD_NBR:
                            if (!xok) st_reg <= ST_RANGE;
                            else
                            begin
                                scan_reg <= rows_reg[xi];
                                found_reg <= 1'b0;
                                state_reg <= S_NBR;
                            end
                        CMD_GET_V:
                            if (!xok) st_reg <= ST_RANGE;
                            else rv_reg <= 16'(vval_reg[xi]);
                        CMD_SET_V:
                            if (!xok) st_reg <= ST_RANGE;
                            else vval_reg[xi] <= VERTEX_VALUE_BITS'(val_reg);
                        CMD_GET_E:
                            if (!xyok) st_reg <= ST_RANGE;
                            else state_reg <= S_RD_E;
                        CMD_SET_E:
                            if (!xyok) st_reg <= ST_RANGE;
                        default: ;
                    endcase
                    if (state_reg == S_DONE && !(cmd_reg == CMD_ADD_V || cmd_reg == CMD_REM_V
                        || cmd_reg == CMD_NBR || cmd_reg == CMD_GET_E))
                        ov_reg <= 1'b1;
                    if (cmd_reg == CMD_ADD_V && n_reg >= CW'(MAX_VERTICES)) ov_reg <= 1'b1;
                    if ((cmd_reg == CMD_REM_V || cmd_reg == CMD_NBR) && !xok) ov_reg <= 1'b1;
                    if (cmd_reg == CMD_GET_E && !xyok) ov_reg <= 1'b1;
                end
                S_ADD_E:
                begin
                    cj_reg <= cj_reg + 1'b1;
                    if (cj_reg == IW'(MAX_VERTICES - 1))
                    begin
                        ci_reg <= ci_reg + 1'b1;
                        if (ci_reg[0])
                        begin
                            n_reg <= n_reg + 1'b1;
                            ov_reg <= 1'b1;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_REM_RD: state_reg <= S_REM_WR;
                S_REM_WR:
                begin
                    cj_reg <= cj_reg + 1'b1;
                    if (cj_reg == IW'(MAX_VERTICES - 1)) ci_reg <= ci_reg + 1'b1;
                    if (sweep_end)
                    begin
                        n_reg <= n_reg - 1'b1;
                        ov_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                    else
                        state_reg <= S_REM_RD;
                end
                S_RD_E: state_reg <= S_RD_E2;
                S_RD_E2:
                begin
                    rv_reg <= 16'(erd_reg);
                    ov_reg <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_NBR:
                begin
                    // one row bit per cycle; a waiting neighbor item is left untouched
                    if (scan_reg[ci_reg] && ciw < n_reg)
                    begin
                        found_reg <= 1'b1;
                        scan_reg[ci_reg] <= 1'b0;
                        state_reg <= S_NBR_OUT;
                    end
                    else if (ci_reg == IW'(MAX_VERTICES - 1) || ciw + 1'b1 >= n_reg)
                    begin
                        if (!found_reg)
                        begin
                            st_reg <= ST_NONE;
                            rv_reg <= '0;
                            ni_reg <= '0;
                            last_reg <= 1'b1;
                            ov_reg <= 1'b1;
                        end
                        state_reg <= S_WAIT;
                    end
                    else
                        ci_reg <= ci_reg + 1'b1;
                end
                S_NBR_OUT:
                begin
                    // load the neighbor item once the output is free; last if none above
                    if (!ov_reg)
                    begin
                        logic more;
                        more = 1'b0;
                        for (int k = 0; k < MAX_VERTICES; k++)
                            if (scan_reg[k] && CW'(k) < n_reg) more = 1'b1;
                        st_reg <= ST_OK;
                        rv_reg <= 16'(vval_reg[ci_reg]);
                        ni_reg <= 4'(ci_reg);
                        last_reg <= !more;
                        ov_reg <= 1'b1;
                        state_reg <= more ? S_NBR : S_WAIT;
                    end
                end
                S_WAIT:
                    if (!ov_reg || out_fire) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign is_adjacent    = adj_reg;
    assign read_value     = rv_reg;
    assign neighbor_index = ni_reg;
    assign vertex_total   = 5'(n_reg);
    assign last           = last_reg;

    `AMG_ASSERT_NOW(a_no_accept_busy, state_reg != S_IDLE, !in_ready)
    `AMG_ASSERT_NOW(a_count_bound, 1'b1, n_reg <= CW'(MAX_VERTICES))
    `AMG_ASSERT_NEXT(a_accept_busy, in_fire, !in_ready)
    `AMG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(neighbor_index) && $stable(last))
endmodule

// File: tb/sv/adjacency_matrix_graph_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_tb
// Drives graph commands through valid/ready, predicts each answer from a
// software copy of the graph, and checks results in order, field by field.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_tb;
    import amg_pkg::*;

    localparam int NV        = 16;
    localparam int STALL_MAX = 2000;
    localparam int DRAIN     = 400;   // remove vertex sweeps every edge cell; add vertex sweeps row n and column n

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [15:0] val;
        logic        opt;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  st;
        logic        adj;
        logic [15:0] rval;
        logic [3:0]  nidx;
        logic [4:0]  total;
        logic        lst;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  command;
    logic [3:0]  first_index;
    logic [3:0]  second_index;
    logic [15:0] value;
    logic        option_flag;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        is_adjacent;
    logic [15:0] read_value;
    logic [3:0]  neighbor_index;
    logic [4:0]  vertex_total;
    logic        last;

    adjacency_matrix_graph_store dut (.*);

    // shadow graph
    logic [4:0]  g_count;
    logic [15:0] g_rows [NV];
    logic [15:0] g_vals [NV];
    logic [15:0] g_edge [NV][NV];

    cmd_item_t pending_cmds[$];
    answer_t   expected_answers[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;
    int  errors;
    int  n_cmds;
    int  n_answers;
    int  n_lists;
    int  quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic answer_t mk(logic [1:0] st, logic adj, logic [15:0] rv,
                                   logic [3:0] ni, logic lst);
        answer_t a;
        a.st = st; a.adj = adj; a.rval = rv; a.nidx = ni;
        a.total = g_count; a.lst = lst;
        return a;
    endfunction

    // append to the tail of the answer and command queues
    task automatic put_answer(input answer_t a);
        expected_answers.insert(expected_answers.size(), a);
    endtask

    task automatic put_cmd(input cmd_item_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // apply one command to the shadow graph and queue what it answers
    task automatic predict_graph_cmd(input cmd_item_t c);
        int n;
        int k;
        bit xok;
        bit xyok;
        logic [15:0] r;
        n = g_count;
        xok = c.x < n;
        xyok = xok && (c.y < n);
        case (c.cmd)
            CMD_ADD_V:
            begin
                if (n >= NV)
                    put_answer(mk(ST_FULL, 0, 0, 0, 1));
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        g_rows[i][n] = 1'b0;
                        g_edge[i][n] = '0;
                    end
                    for (int j = 0; j < NV; j++)
                        g_edge[n][j] = '0;
                    g_rows[n] = '0;
                    g_rows[n][n] = c.opt;
                    g_vals[n] = c.val;
                    g_count = n + 1;
                    put_answer(mk(ST_OK, 0, 0, 0, 1));
                end
            end
            CMD_REM_V:
            begin
                if (!xok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                begin
                    for (int i = c.x; i + 1 < n; i++)
                    begin
                        g_rows[i] = g_rows[i+1];
                        g_vals[i] = g_vals[i+1];
                        for (int j = 0; j < NV; j++)
                            g_edge[i][j] = g_edge[i+1][j];
                    end
                    g_rows[n-1] = '0;
                    g_vals[n-1] = '0;
                    for (int j = 0; j < NV; j++)
                        g_edge[n-1][j] = '0;
                    for (int i = 0; i + 1 < n; i++)
                    begin
                        r = '0;
                        for (int b = 0; b < NV; b++)
                            if (b < c.x)
                                r[b] = g_rows[i][b];
                            else if (b + 1 < NV)
                                r[b] = g_rows[i][b+1];
                        g_rows[i] = r;
                        for (int j = c.x; j + 1 < n; j++)
                            g_edge[i][j] = g_edge[i][j+1];
                        g_edge[i][n-1] = '0;
                    end
                    g_count = n - 1;
                    put_answer(mk(ST_OK, 0, 0, 0, 1));
                end
            end
            CMD_ADD_E, CMD_REM_E:
            begin
                if (!xyok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                begin
                    g_rows[c.x][c.y] = (c.cmd == CMD_ADD_E);
                    if (c.opt)
                        g_rows[c.y][c.x] = (c.cmd == CMD_ADD_E);
                    put_answer(mk(ST_OK, 0, 0, 0, 1));
                end
            end
            CMD_ADJ:
                if (!xyok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                    put_answer(mk(ST_OK, g_rows[c.x][c.y], 0, 0, 1));
            CMD_NBR:
            begin
                if (!xok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                begin
                    k = 0;
                    n_lists++;
                    for (int i = 0; i < n; i++)
                        if (g_rows[c.x][i])
                        begin
                            put_answer(mk(ST_OK, 0, g_vals[i], i, 0));
                            k++;
                        end
                    if (k == 0)
                        put_answer(mk(ST_NONE, 0, 0, 0, 1));
                    else
                        expected_answers[$].lst = 1'b1;
                end
            end
            CMD_GET_V:
                if (!xok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                    put_answer(mk(ST_OK, 0, g_vals[c.x], 0, 1));
            CMD_SET_V:
            begin
                if (xok)
                    g_vals[c.x] = c.val;
                put_answer(mk(xok ? ST_OK : ST_RANGE, 0, 0, 0, 1));
            end
            CMD_GET_E:
                if (!xyok)
                    put_answer(mk(ST_RANGE, 0, 0, 0, 1));
                else
                    put_answer(mk(ST_OK, 0, g_edge[c.x][c.y], 0, 1));
            CMD_SET_E:
            begin
                if (xyok)
                    g_edge[c.x][c.y] = c.val;
                put_answer(mk(xyok ? ST_OK : ST_RANGE, 0, 0, 0, 1));
            end
            default:
                put_answer(mk(ST_OK, 0, 0, 0, 1));
        endcase
    endtask

    function automatic cmd_item_t mk_cmd(logic [3:0] cmd, logic [3:0] x, logic [3:0] y,
                                         logic [15:0] v, logic o);
        cmd_item_t c;
        c.cmd = cmd; c.x = x; c.y = y; c.val = v; c.opt = o;
        return c;
    endfunction

    // random command, biased toward indices that are live in a graph of size n
    function automatic cmd_item_t rand_cmd(int n);
        cmd_item_t c;
        int p;
        p = $urandom_range(99);
        if (p < 3)
            c.cmd = $urandom_range(15, 10);
        else if (p < 18)
            c.cmd = CMD_ADD_V;
        else if (p < 24)
            c.cmd = CMD_REM_V;
        else if (p < 44)
            c.cmd = CMD_ADD_E;
        else
            c.cmd = $urandom_range(9, 3);
        c.x = ($urandom_range(9) == 0 || n == 0) ? $urandom_range(15) : $urandom_range(n - 1);
        c.y = ($urandom_range(9) == 0 || n == 0) ? $urandom_range(15) : $urandom_range(n - 1);
        c.val = $urandom;
        c.opt = $urandom_range(1);
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            command      <= '0;
            first_index  <= '0;
            second_index <= '0;
            value        <= '0;
            option_flag  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_graph_cmd(pending_cmds.pop_front());
                n_cmds++;
            end
            // next item goes up only once the prior is gone or none is up
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid     <= 1'b1;
                    command      <= pending_cmds[0].cmd;
                    first_index  <= pending_cmds[0].x;
                    second_index <= pending_cmds[0].y;
                    value        <= pending_cmds[0].val;
                    option_flag  <= pending_cmds[0].opt;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
            begin
                n_answers++;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result st=%0d idx=%0d val=%h", $time,
                             status, neighbor_index, read_value);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.st || is_adjacent !== want.adj
                        || read_value !== want.rval || neighbor_index !== want.nidx
                        || vertex_total !== want.total || last !== want.lst)
                    begin
                        $display("%0t: expected st=%0d adj=%0d val=%h idx=%0d tot=%0d last=%0d",
                                 $time, want.st, want.adj, want.rval, want.nidx,
                                 want.total, want.lst);
                        $display("%0t: actual   st=%0d adj=%0d val=%h idx=%0d tot=%0d last=%0d",
                                 $time, status, is_adjacent, read_value, neighbor_index,
                                 vertex_total, last);
                        errors++;
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("watchdog: no traffic for %0d cycles", STALL_MAX);
            $display("tb: failure");
            $finish;
        end
    end

    // -------------------------------------------------------------- stimulus
    initial
    begin
        int n;
        cmd_item_t c;
        errors = 0; n_cmds = 0; n_answers = 0; n_lists = 0;
        hold_sender = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 59;
        g_count = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-graph range errors, unknown op, fill, full, listings
        put_cmd(mk_cmd(CMD_REM_V, 0, 0, 0, 0));
        put_cmd(mk_cmd(CMD_NBR, 0, 0, 0, 0));
        put_cmd(mk_cmd(4'd15, 4'hf, 4'hf, 16'hffff, 1));
        put_cmd(mk_cmd(CMD_ADD_V, 0, 0, 16'hffff, 1));
        put_cmd(mk_cmd(CMD_ADD_V, 0, 0, 16'h0000, 0));
        put_cmd(mk_cmd(CMD_NBR, 1, 0, 0, 0));          // empty row
        put_cmd(mk_cmd(CMD_ADD_E, 1, 0, 0, 1));
        put_cmd(mk_cmd(CMD_NBR, 0, 0, 0, 0));
        put_cmd(mk_cmd(CMD_SET_E, 0, 1, 16'ha5a5, 0));
        put_cmd(mk_cmd(CMD_GET_E, 0, 1, 0, 0));
        put_cmd(mk_cmd(CMD_GET_E, 0, 2, 0, 0));        // y out of range
        for (int i = 2; i < NV; i++)
            put_cmd(mk_cmd(CMD_ADD_V, 0, 0, $urandom, i[0]));
        put_cmd(mk_cmd(CMD_ADD_V, 0, 0, 16'h1234, 1)); // full
        put_cmd(mk_cmd(CMD_ADJ, 15, 15, 0, 0));
        put_cmd(mk_cmd(CMD_SET_V, 15, 0, 16'h8001, 0));
        put_cmd(mk_cmd(CMD_GET_V, 15, 0, 0, 0));
        put_cmd(mk_cmd(CMD_REM_E, 0, 1, 0, 1));
        put_cmd(mk_cmd(CMD_REM_V, 0, 0, 0, 0));
        put_cmd(mk_cmd(CMD_GET_V, 15, 0, 0, 0));       // now out of range
        n = NV - 1;

        // random commands in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            wait_drained();
            if (ph == 1)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 32;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 80; k++)
            begin
                c = rand_cmd(n);
                // track live size for index bias; rough is fine
                if (c.cmd == CMD_ADD_V && n < NV)
                    n++;
                else if (c.cmd == CMD_REM_V && c.x < n)
                    n--;
                // an occasional full listing of a dense row
                if (k % 40 == 20)
                    for (int j = 0; j < n; j++)
                        put_cmd(mk_cmd(CMD_ADD_E, 0, j, 0, 1));
                put_cmd(c);
                if (k % 40 == 20)
                    put_cmd(mk_cmd(CMD_NBR, 0, 0, 0, 0));
                // sender holds off until every answer is in
                if (k == 60)
                begin
                    hold_sender = 1'b1;
                    while (expected_answers.size() != 0 || in_valid)
                        @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
        end
        wait_drained();
        repeat (DRAIN) @(posedge clk);
        $display("run: %0d commands, %0d results checked, %0d neighbor listings",
                 n_cmds, n_answers, n_lists);
        $display("run: covered full/empty store, range errors, removal compaction");
        if (errors == 0 && expected_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
